FILE: hw/rtl/sosc_pkg.sv
// ----------------------------------------------------------------------------
// sosc_pkg
// Shared types, widths and codes for the segmented odd-only prime sieve counter.
// ----------------------------------------------------------------------------
package sosc_pkg;

    localparam int LIMIT_WIDTH          = 32;
    localparam int SEGMENT_ODDS_DEFAULT = 65536;
    localparam int BASE_ODDS_DEFAULT    = 32768;

    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int RESULT_W = 32;
    localparam int STATUS_W = 2;

    // working width for bounds, offsets and products
    localparam int VAL_W   = LIMIT_WIDTH + 2;
    localparam int ROOT_W  = LIMIT_WIDTH / 2;
    localparam int MUL_B_W = (ROOT_W + 1 > COUNT_W) ? ROOT_W + 1 : COUNT_W;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_MANY  = 2'd1,
        STATUS_BAD_INDEX = 2'd2,
        STATUS_OVERSIZE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] upper_limit;
        logic [COUNT_W-1:0]     segment_count;
        logic [INDEX_W-1:0]     segment_index;
    } in_item_t;

    typedef struct packed {
        logic [RESULT_W-1:0] prime_count;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] dividend;
        logic [VAL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [VAL_W-1:0] quotient;
        logic [VAL_W-1:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic                   start;
        logic [LIMIT_WIDTH-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              busy;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PRE,
        ST_ROOT_WAIT,
        ST_CHECK,
        ST_LOW_MQ,
        ST_LOW_MR,
        ST_LOW_DS,
        ST_LOW_DW,
        ST_HIGH_MQ,
        ST_HIGH_MR,
        ST_HIGH_DS,
        ST_HIGH_DW,
        ST_SIZE,
        ST_CLEAR,
        ST_BASE_RD,
        ST_BASE_CHK,
        ST_BASE_MARK,
        ST_SEG_RD,
        ST_SEG_CHK,
        ST_SEG_DW,
        ST_SEG_ADJ,
        ST_SEG_MARK,
        ST_COUNT,
        ST_COUNT_END,
        ST_FINISH
    } state_t;

endpackage

FILE: hw/rtl/segmented_odd_prime_sieve_count.sv
// ----------------------------------------------------------------------------
// segmented_odd_prime_sieve_count
// Sequence: setup with three divides (the first alongside the square root),
//   then a clear sweep over max(nb, size) entries, the base sieve, a divide
//   per base prime that reaches the segment plus its marking writes, and a counting sweep.
// Throughput: one item at a time, set by the two-port mark stores and the
//   shared divider. Reset clears control only; stores are swept per item.
// ----------------------------------------------------------------------------
module segmented_odd_prime_sieve_count #(
    parameter int SEGMENT_ODDS = sosc_pkg::SEGMENT_ODDS_DEFAULT,
    parameter int BASE_ODDS    = sosc_pkg::BASE_ODDS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sosc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sosc_pkg::out_item_t m_data
);

    localparam int VW     = sosc_pkg::VAL_W;
    localparam int LW     = sosc_pkg::LIMIT_WIDTH;
    localparam int MB     = sosc_pkg::MUL_B_W;
    localparam int CNTW   = sosc_pkg::COUNT_W;
    localparam int IDXW   = sosc_pkg::INDEX_W;
    localparam int RESW   = sosc_pkg::RESULT_W;
    localparam int SEG_AW  = $clog2(SEGMENT_ODDS);
    localparam int BASE_AW = $clog2(BASE_ODDS);

    // sequencer state
    sosc_pkg::state_t state_reg, state_next;

    // latched request
    logic [LW-1:0]   n_reg, n_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [IDXW-1:0] idx_reg, idx_next;

    // derived bounds
    logic [VW-1:0] q_reg, q_next;
    logic [VW-1:0] r_reg, r_next;
    logic [sosc_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [VW-1:0] nb_reg, nb_next;
    logic [VW-1:0] acc_reg, acc_next;
    logic [VW-1:0] low_reg, low_next;
    logic [VW-1:0] high_reg, high_next;
    logic [VW-1:0] size_reg, size_next;
    logic [VW-1:0] clr_end_reg, clr_end_next;

    // loop counters
    logic [VW-1:0] i_reg, i_next;
    logic [VW-1:0] j_reg, j_next;
    logic [VW-1:0] m_reg, m_next;
    logic [RESW-1:0] count_reg, count_next;
    logic pend_reg, pend_next;

    // pending and delivered result
    logic [RESW-1:0] res_count_reg, res_count_next;
    sosc_pkg::status_t res_status_reg, res_status_next;
    sosc_pkg::out_item_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;

    // shared multiplier, registered
    logic [VW-1:0]    mul_a;
    logic [MB-1:0]    mul_b;
    logic [VW+MB-1:0] mul_prod;
    logic [VW-1:0]    mul_reg;

    // shared units
    sosc_pkg::div_req_t  div_req;
    sosc_pkg::div_rsp_t  div_rsp;
    sosc_pkg::sqrt_req_t sqrt_req;
    sosc_pkg::sqrt_rsp_t sqrt_rsp;

    // mark stores, one write and one read port each
    logic base_mem [BASE_ODDS];
    logic seg_mem  [SEGMENT_ODDS];
    logic               base_we, base_wdata, base_rdata_reg;
    logic [BASE_AW-1:0] base_waddr, base_raddr;
    logic               seg_we, seg_wdata, seg_rdata_reg;
    logic [SEG_AW-1:0]  seg_waddr, seg_raddr;

    // common combinational terms
    logic [VW-1:0] n_w, root_w, cnt_w, odd_i, nb_w;
    logic [VW-1:0] low_adj, high_adj, size_w;
    logic [VW-1:0] seg_start, m_odd;
    logic          too_many, bad_index, nb_big;

    assign n_w     = VW'(n_reg);
    assign root_w  = VW'(root_reg);
    assign cnt_w   = VW'(cnt_reg);
    // odd value 3 + 2i for the current base index
    assign odd_i   = VW'(3) + {i_reg[VW-2:0], 1'b0};
    assign nb_w    = (root_w - VW'(1)) >> 1;
    assign too_many  = (VW'(2) + q_reg) < root_w;
    assign bad_index = {1'b0, idx_reg} >= cnt_reg;
    assign nb_big    = nb_w > VW'(BASE_ODDS);

    // segment ends rounded inward to odd values
    assign low_adj  = low_reg | VW'(1);
    assign high_adj = high_reg[0] ? high_reg : high_reg - VW'(1);
    assign size_w   = (high_adj >= low_adj) ? ((high_adj - low_adj) >> 1) + VW'(1) : '0;

    // first candidate: larger of p*p and the segment low end
    assign seg_start = (mul_reg < low_reg) ? low_reg : mul_reg;
    assign m_odd     = m_reg[0] ? m_reg : m_reg + odd_i;

    assign mul_prod = mul_a * mul_b;

    sosc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    sosc_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sqrt_req),
        .rsp     (sqrt_rsp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sosc_pkg::ST_IDLE: begin
                if (s_valid) state_next = sosc_pkg::ST_PRE;
            end
            sosc_pkg::ST_PRE: begin
                if (cnt_reg == '0 || n_reg < LW'(3)) state_next = sosc_pkg::ST_FINISH;
                else                                 state_next = sosc_pkg::ST_ROOT_WAIT;
            end
            sosc_pkg::ST_ROOT_WAIT: begin
                if (!div_rsp.busy && !sqrt_rsp.busy) state_next = sosc_pkg::ST_CHECK;
            end
            sosc_pkg::ST_CHECK: begin
                if (too_many || bad_index || nb_big) state_next = sosc_pkg::ST_FINISH;
                else                                 state_next = sosc_pkg::ST_LOW_MQ;
            end
            sosc_pkg::ST_LOW_MQ:  state_next = sosc_pkg::ST_LOW_MR;
            sosc_pkg::ST_LOW_MR:  state_next = sosc_pkg::ST_LOW_DS;
            sosc_pkg::ST_LOW_DS:  state_next = sosc_pkg::ST_LOW_DW;
            sosc_pkg::ST_LOW_DW: begin
                if (!div_rsp.busy) state_next = sosc_pkg::ST_HIGH_MQ;
            end
            sosc_pkg::ST_HIGH_MQ: state_next = sosc_pkg::ST_HIGH_MR;
            sosc_pkg::ST_HIGH_MR: state_next = sosc_pkg::ST_HIGH_DS;
            sosc_pkg::ST_HIGH_DS: state_next = sosc_pkg::ST_HIGH_DW;
            sosc_pkg::ST_HIGH_DW: begin
                if (!div_rsp.busy) state_next = sosc_pkg::ST_SIZE;
            end
            sosc_pkg::ST_SIZE: begin
                if (size_w > VW'(SEGMENT_ODDS)) state_next = sosc_pkg::ST_FINISH;
                else                            state_next = sosc_pkg::ST_CLEAR;
            end
            sosc_pkg::ST_CLEAR: begin
                if (j_reg >= clr_end_reg) state_next = sosc_pkg::ST_BASE_RD;
            end
            sosc_pkg::ST_BASE_RD: begin
                if (i_reg >= nb_reg) state_next = sosc_pkg::ST_SEG_RD;
                else                 state_next = sosc_pkg::ST_BASE_CHK;
            end
            sosc_pkg::ST_BASE_CHK: begin
                if (mul_reg > root_w)    state_next = sosc_pkg::ST_SEG_RD;
                else if (base_rdata_reg) state_next = sosc_pkg::ST_BASE_RD;
                else                     state_next = sosc_pkg::ST_BASE_MARK;
            end
            sosc_pkg::ST_BASE_MARK: begin
                if (j_reg >= nb_reg) state_next = sosc_pkg::ST_BASE_RD;
            end
            sosc_pkg::ST_SEG_RD: begin
                if (i_reg >= nb_reg || size_reg == '0) state_next = sosc_pkg::ST_COUNT;
                else                                   state_next = sosc_pkg::ST_SEG_CHK;
            end
            sosc_pkg::ST_SEG_CHK: begin
                if (base_rdata_reg || seg_start > high_reg) state_next = sosc_pkg::ST_SEG_RD;
                else                                        state_next = sosc_pkg::ST_SEG_DW;
            end
            sosc_pkg::ST_SEG_DW: begin
                if (!div_rsp.busy) state_next = sosc_pkg::ST_SEG_ADJ;
            end
            sosc_pkg::ST_SEG_ADJ: begin
                if (m_odd > high_reg) state_next = sosc_pkg::ST_SEG_RD;
                else                  state_next = sosc_pkg::ST_SEG_MARK;
            end
            sosc_pkg::ST_SEG_MARK: begin
                if (j_reg >= size_reg) state_next = sosc_pkg::ST_SEG_RD;
            end
            sosc_pkg::ST_COUNT: begin
                if (j_reg >= size_reg) state_next = sosc_pkg::ST_COUNT_END;
            end
            sosc_pkg::ST_COUNT_END: state_next = sosc_pkg::ST_FINISH;
            sosc_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) state_next = sosc_pkg::ST_IDLE;
            end
            default: state_next = sosc_pkg::ST_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb begin
        n_next          = n_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        q_next          = q_reg;
        r_next          = r_reg;
        root_next       = root_reg;
        nb_next         = nb_reg;
        acc_next        = acc_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        size_next       = size_reg;
        clr_end_next    = clr_end_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        m_next          = m_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg;

        mul_a = '0;
        mul_b = '0;
        div_req  = '0;
        sqrt_req = '0;

        base_we    = 1'b0;
        base_wdata = 1'b0;
        base_waddr = j_reg[BASE_AW-1:0];
        base_raddr = i_reg[BASE_AW-1:0];
        seg_we     = 1'b0;
        seg_wdata  = 1'b0;
        seg_waddr  = j_reg[SEG_AW-1:0];
        seg_raddr  = j_reg[SEG_AW-1:0];

        // counting pipe: one read a cycle, data in the cycle after
        pend_next  = (state_reg == sosc_pkg::ST_COUNT) && (j_reg < size_reg);
        count_next = count_reg + RESW'(pend_reg && !seg_rdata_reg);

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            sosc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    n_next   = s_data.upper_limit;
                    cnt_next = s_data.segment_count;
                    idx_next = s_data.segment_index;
                end
            end
            sosc_pkg::ST_PRE: begin
                res_count_next = '0;
                if (cnt_reg == '0) begin
                    res_status_next = sosc_pkg::STATUS_TOO_MANY;
                end else if (n_reg < LW'(3)) begin
                    // no odd range: only the prime 2 can count
                    if (bad_index) begin
                        res_status_next = sosc_pkg::STATUS_BAD_INDEX;
                    end else begin
                        res_status_next = sosc_pkg::STATUS_OK;
                        res_count_next  = RESW'(idx_reg == '0 && n_reg == LW'(2));
                    end
                end else begin
                    div_req.start     = 1'b1;
                    div_req.dividend  = n_w - VW'(1);
                    div_req.divisor   = cnt_w;
                    sqrt_req.start    = 1'b1;
                    sqrt_req.radicand = n_reg;
                end
            end
            sosc_pkg::ST_ROOT_WAIT: begin
                if (!div_rsp.busy && !sqrt_rsp.busy) begin
                    q_next    = div_rsp.quotient;
                    r_next    = div_rsp.remainder;
                    root_next = sqrt_rsp.root;
                end
            end
            sosc_pkg::ST_CHECK: begin
                nb_next        = nb_w;
                res_count_next = '0;
                if (too_many)       res_status_next = sosc_pkg::STATUS_TOO_MANY;
                else if (bad_index) res_status_next = sosc_pkg::STATUS_BAD_INDEX;
                else if (nb_big)    res_status_next = sosc_pkg::STATUS_OVERSIZE;
            end
            sosc_pkg::ST_LOW_MQ: begin
                mul_a = q_reg;
                mul_b = MB'(idx_reg);
            end
            sosc_pkg::ST_LOW_MR: begin
                acc_next = VW'(3) + mul_reg;
                mul_a    = r_reg;
                mul_b    = MB'(idx_reg);
            end
            sosc_pkg::ST_LOW_DS, sosc_pkg::ST_HIGH_DS: begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_reg;
                div_req.divisor  = cnt_w;
            end
            sosc_pkg::ST_LOW_DW: begin
                if (!div_rsp.busy) low_next = acc_reg + div_rsp.quotient;
            end
            sosc_pkg::ST_HIGH_MQ: begin
                mul_a = q_reg;
                mul_b = MB'(idx_reg) + MB'(1);
            end
            sosc_pkg::ST_HIGH_MR: begin
                acc_next = VW'(2) + mul_reg;
                mul_a    = r_reg;
                mul_b    = MB'(idx_reg) + MB'(1);
            end
            sosc_pkg::ST_HIGH_DW: begin
                if (!div_rsp.busy) high_next = acc_reg + div_rsp.quotient;
            end
            sosc_pkg::ST_SIZE: begin
                low_next     = low_adj;
                high_next    = high_adj;
                size_next    = size_w;
                clr_end_next = (nb_reg > size_w) ? nb_reg : size_w;
                j_next       = '0;
                if (size_w > VW'(SEGMENT_ODDS)) begin
                    res_count_next  = '0;
                    res_status_next = sosc_pkg::STATUS_OVERSIZE;
                end
            end
            sosc_pkg::ST_CLEAR: begin
                if (j_reg < clr_end_reg) begin
                    base_we = j_reg < nb_reg;
                    seg_we  = j_reg < size_reg;
                    j_next  = j_reg + VW'(1);
                end else begin
                    i_next = '0;
                end
            end
            sosc_pkg::ST_BASE_RD, sosc_pkg::ST_SEG_RD: begin
                mul_a = odd_i;
                mul_b = odd_i[MB-1:0];
                if (state_reg == sosc_pkg::ST_BASE_RD) begin
                    if (i_reg >= nb_reg) i_next = '0;
                end else if (i_reg >= nb_reg || size_reg == '0) begin
                    j_next = '0;
                end
            end
            sosc_pkg::ST_BASE_CHK: begin
                if (mul_reg > root_w)    i_next = '0;
                else if (base_rdata_reg) i_next = i_reg + VW'(1);
                else                     j_next = (mul_reg - VW'(3)) >> 1;
            end
            sosc_pkg::ST_BASE_MARK: begin
                if (j_reg < nb_reg) begin
                    base_we    = 1'b1;
                    base_wdata = 1'b1;
                    j_next     = j_reg + odd_i;
                end else begin
                    i_next = i_reg + VW'(1);
                end
            end
            sosc_pkg::ST_SEG_CHK: begin
                if (base_rdata_reg || seg_start > high_reg) begin
                    i_next = i_reg + VW'(1);
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = seg_start;
                    div_req.divisor  = odd_i;
                    m_next           = seg_start;
                end
            end
            sosc_pkg::ST_SEG_DW: begin
                // round up to the next multiple of p
                if (!div_rsp.busy && div_rsp.remainder != '0) begin
                    m_next = m_reg + (odd_i - div_rsp.remainder);
                end
            end
            sosc_pkg::ST_SEG_ADJ: begin
                if (m_odd > high_reg) i_next = i_reg + VW'(1);
                else                  j_next = (m_odd - low_reg) >> 1;
            end
            sosc_pkg::ST_SEG_MARK: begin
                if (j_reg < size_reg) begin
                    seg_we    = 1'b1;
                    seg_wdata = 1'b1;
                    j_next    = j_reg + odd_i;
                end else begin
                    i_next = i_reg + VW'(1);
                end
            end
            sosc_pkg::ST_COUNT: begin
                if (j_reg < size_reg) j_next = j_reg + VW'(1);
            end
            sosc_pkg::ST_COUNT_END: begin
                res_count_next  = count_reg + RESW'(idx_reg == '0);
                res_status_next = sosc_pkg::STATUS_OK;
            end
            sosc_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.prime_count = res_count_reg;
                    out_next.status      = res_status_reg;
                    m_valid_next         = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // counter restarts as the count sweep begins
        if (state_reg == sosc_pkg::ST_SEG_RD && state_next == sosc_pkg::ST_COUNT) begin
            count_next = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sosc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        q_reg          <= q_next;
        r_reg          <= r_next;
        root_reg       <= root_next;
        nb_reg         <= nb_next;
        acc_reg        <= acc_next;
        low_reg        <= low_next;
        high_reg       <= high_next;
        size_reg       <= size_next;
        clr_end_reg    <= clr_end_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        m_reg          <= m_next;
        count_reg      <= count_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
        mul_reg        <= mul_prod[VW-1:0];
    end

    // base prime marks
    always_ff @(posedge aclk) begin
        if (base_we) base_mem[base_waddr] <= base_wdata;
        base_rdata_reg <= base_mem[base_raddr];
    end

    // segment marks
    always_ff @(posedge aclk) begin
        if (seg_we) seg_mem[seg_waddr] <= seg_wdata;
        seg_rdata_reg <= seg_mem[seg_raddr];
    end

    assign s_ready = (state_reg == sosc_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // error results carry a zero count
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != sosc_pkg::STATUS_OK |-> m_data.prime_count == '0)
        else $error("error result with nonzero count");

    // one item in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    // root is ready no later than the quotient
    a_root_first: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sosc_pkg::ST_ROOT_WAIT && !div_rsp.busy |-> !sqrt_rsp.busy)
        else $error("square root still running");

    // unmarked tally never exceeds the segment
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sosc_pkg::ST_COUNT_END |-> VW'(count_reg) <= size_reg)
        else $error("count exceeds segment size");

    // marking writes stay inside the live range
    a_mark_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_we && seg_wdata |-> j_reg < size_reg)
        else $error("segment mark out of range");

endmodule

FILE: hw/rtl/sosc_divider.sv
// ----------------------------------------------------------------------------
// sosc_divider
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
module sosc_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  sosc_pkg::div_req_t  req,
    output sosc_pkg::div_rsp_t  rsp
);

    localparam int W  = sosc_pkg::VAL_W;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] step_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dvs_reg;

    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + CW'(1);
            if (step_reg == CW'(W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: hw/rtl/sosc_sqrt.sv
// ----------------------------------------------------------------------------
// sosc_sqrt
// Integer floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sosc_sqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  sosc_pkg::sqrt_req_t req,
    output sosc_pkg::sqrt_rsp_t rsp
);

    localparam int LW = sosc_pkg::LIMIT_WIDTH;
    localparam int RW = sosc_pkg::ROOT_W;
    localparam int EW = RW + 4;
    localparam int CW = $clog2(RW + 1);

    logic          busy_reg;
    logic [CW-1:0] step_reg;
    logic [LW-1:0] x_reg;
    logic [EW-1:0] rem_reg;
    logic [RW-1:0] root_reg;

    logic [EW-1:0] rem_sh;
    logic [EW-1:0] trial;
    logic          ge;

    assign rem_sh = {rem_reg[EW-3:0], x_reg[LW-1 -: 2]};
    assign trial  = {{(EW-RW-2){1'b0}}, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + CW'(1);
            if (step_reg == CW'(RW - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            x_reg    <= req.radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[LW-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.root = root_reg;

endmodule

FILE: verif/tb_segmented_odd_prime_sieve_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segmented_odd_prime_sieve_count
// Drives sieve requests through the valid/ready input channel and checks
// every returned prime count and status against an in-bench odd-only
// segmented sieve, with bursty sending and a patterned result stall.
// ----------------------------------------------------------------------------
module tb_segmented_odd_prime_sieve_count;

    localparam int CYCLE_LIMIT = 200_000_000;
    localparam int SEG_DEPTH   = sosc_pkg::SEGMENT_ODDS_DEFAULT;
    localparam int BASE_DEPTH  = sosc_pkg::BASE_ODDS_DEFAULT;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    sosc_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    sosc_pkg::out_item_t m_data;

    // items waiting to be sent and counts waiting to come back
    sosc_pkg::in_item_t  send_queue[$];
    sosc_pkg::out_item_t count_queue[$];

    // private mark stores for the predicted sieve
    bit base_composite[BASE_DEPTH];
    bit seg_composite[SEG_DEPTH];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  item_taken = 1'b0;
    int  burst_left = 4;
    int  gap_left = 0;
    int  stall_mode = 0;

    segmented_odd_prime_sieve_count DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // exact integer floor of the square root, bit by bit
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned cand;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= x) root = cand;
        end
        return root;
    endfunction

    // expected prime count and status for one request
    function automatic sosc_pkg::out_item_t sieve_segment(sosc_pkg::in_item_t it);
        sosc_pkg::out_item_t res;
        longint unsigned n, cnt, idx, span, q, r, root, nb;
        longint unsigned low, high, size, start, rem, m, v, p, j;
        longint unsigned tally;
        n   = it.upper_limit;
        cnt = it.segment_count;
        idx = it.segment_index;
        res.prime_count = '0;
        res.status      = sosc_pkg::STATUS_OK;
        if (cnt == 0) begin
            res.status = sosc_pkg::STATUS_TOO_MANY;
            return res;
        end
        // no odd range below three
        if (n < 3) begin
            if (idx >= cnt) res.status = sosc_pkg::STATUS_BAD_INDEX;
            else res.prime_count = (idx == 0 && n == 2) ? 32'd1 : 32'd0;
            return res;
        end
        span = n - 1;
        q    = span / cnt;
        r    = span % cnt;
        root = int_sqrt(n);
        if (2 + q < root) begin
            res.status = sosc_pkg::STATUS_TOO_MANY;
            return res;
        end
        if (idx >= cnt) begin
            res.status = sosc_pkg::STATUS_BAD_INDEX;
            return res;
        end
        nb = (root >= 3) ? (root - 3) / 2 + 1 : 0;
        if (nb > BASE_DEPTH) begin
            res.status = sosc_pkg::STATUS_OVERSIZE;
            return res;
        end
        low  = 3 + idx * q + (idx * r) / cnt;
        high = 2 + (idx + 1) * q + ((idx + 1) * r) / cnt;
        if (low[0] == 1'b0) low = low + 1;
        if (high[0] == 1'b0) high = high - 1;
        size = (high >= low) ? (high - low) / 2 + 1 : 0;
        if (size > SEG_DEPTH) begin
            res.status = sosc_pkg::STATUS_OVERSIZE;
            return res;
        end
        for (longint unsigned i = 0; i < nb; i++) base_composite[i] = 1'b0;
        for (longint unsigned i = 0; i < size; i++) seg_composite[i] = 1'b0;
        // odd base primes up to the root
        for (longint unsigned i = 0; i < nb; i++) begin
            v = 3 + 2 * i;
            if (v > root / v) break;
            if (!base_composite[i])
                for (j = (v * v - 3) / 2; j < nb; j += v) base_composite[j] = 1'b1;
        end
        // odd multiples in the segment from max(p*p, low)
        for (longint unsigned i = 0; i < nb && size > 0; i++) begin
            if (base_composite[i]) continue;
            p = 3 + 2 * i;
            start = p * p;
            if (start < low) start = low;
            if (start > high) continue;
            rem = start % p;
            m = start;
            if (rem != 0) begin
                if (p - rem > high - m) continue;
                m = m + p - rem;
            end
            if (m[0] == 1'b0) begin
                if (p > high - m) continue;
                m = m + p;
            end
            for (j = (m - low) / 2; j < size; j += p) seg_composite[j] = 1'b1;
        end
        tally = (idx == 0) ? 1 : 0;
        for (longint unsigned i = 0; i < size; i++)
            if (!seg_composite[i]) tally++;
        res.prime_count = tally[31:0];
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    task automatic queue_item(logic [31:0] n, logic [10:0] cnt, logic [9:0] idx);
        sosc_pkg::in_item_t it;
        it.upper_limit   = n;
        it.segment_count = cnt;
        it.segment_index = idx;
        send_queue.push_back(it);
    endtask

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[segmented_odd_prime_sieve_count] ERROR");
            $finish;
        end
    end

    // input side: record accepted items and predict their counts
    always @(posedge aclk) begin
        item_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) count_queue.push_back(sieve_segment(s_data));
    end

    // driver: bursts of items separated by random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !item_taken) begin
            // hold until the item is taken
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_valid  <= 1'b0;
        end else if (send_queue.size() > 0) begin
            s_data  <= send_queue.pop_front();
            s_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 8);
                // a zero gap keeps some stretches back to back
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver: stall pattern redrawn from always ready, random or rarely ready
    always @(negedge aclk) begin
        if (cycle_count % 32 == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // monitor: compare each result with the oldest predicted count
    always @(posedge aclk) begin
        sosc_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (count_queue.size() == 0) begin
                report("unexpected item", m_data.prime_count, 0);
            end else begin
                want = count_queue.pop_front();
                if (m_data.prime_count !== want.prime_count)
                    report("prime_count", m_data.prime_count, want.prime_count);
                if (m_data.status !== want.status)
                    report("status", {30'd0, m_data.status}, {30'd0, want.status});
            end
        end
    end

    initial begin
        logic [31:0] n;
        logic [10:0] cnt;
        longint unsigned root, max_cnt;

        // directed: tiny limits, every error, empty segments, extremes
        queue_item(32'd0, 11'd1, 10'd0);
        queue_item(32'd1, 11'd1, 10'd0);
        queue_item(32'd2, 11'd1, 10'd0);
        queue_item(32'd2, 11'd1, 10'd1);
        queue_item(32'd100, 11'd0, 10'd0);
        queue_item(32'd3, 11'd1, 10'd0);
        queue_item(32'd9, 11'd8, 10'd0);
        queue_item(32'd9, 11'd8, 10'd2);
        queue_item(32'd9, 11'd8, 10'd7);
        queue_item(32'd1000000, 11'd2047, 10'd0);
        queue_item(32'd100, 11'd5, 10'd7);
        queue_item(32'hFFFFFFFF, 11'd1, 10'd0);
        queue_item(32'hFFFFFFFF, 11'd2047, 10'd1023);
        queue_item(32'd4000000, 11'd1100, 10'd1023);
        queue_item(32'd50000, 11'd1100, 10'd3);
        queue_item(32'd134000000, 11'd1000, 10'd5);
        queue_item(32'd134000000, 11'd1024, 10'd0);
        queue_item(32'd134000000, 11'd1024, 10'd1023);
        queue_item(32'd1000, 11'd1, 10'd0);
        queue_item(32'd4096, 11'd4, 10'd3);

        // random: mostly small well formed requests, some noise
        for (int k = 0; k < 100; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                n = $urandom_range(3, 4000);
                root = int_sqrt(n);
                max_cnt = (root > 2) ? (n - 1) / (root - 2) : 2047;
                if (max_cnt > 2047) max_cnt = 2047;
                if (max_cnt < 1) max_cnt = 1;
                cnt = 11'($urandom_range(1, max_cnt));
                queue_item(n, cnt, (cnt > 11'd1024) ? 10'($urandom_range(0, 1023))
                                                    : 10'($urandom_range(0, cnt - 1)));
            end else begin
                queue_item($urandom, 11'($urandom_range(0, 2047)),
                           10'($urandom_range(0, 1023)));
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (send_queue.size() > 0 || s_valid) @(posedge aclk);
        while (count_queue.size() > 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        if (error_count == 0) begin
            $display("[segmented_odd_prime_sieve_count] OK");
        end else begin
            $display("[segmented_odd_prime_sieve_count] ERROR");
        end
        $finish;
    end

endmodule
